// File: rtl/bpsr_pkg.sv
// bpsr_pkg: shared types, constants and address helpers for the banked register / psr unit
// no dependencies; used by bpsr_regmem, bpsr_ctrl and banked_register_psr_unit
package bpsr_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned MEM_DEPTH = 42;
    localparam int unsigned MEM_AW = 6;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 64;

    // physical layout of the register memory
    localparam logic [MEM_AW-1:0] USR_BASE = 6'd8;      // user r8-r14
    localparam logic [MEM_AW-1:0] FIQ_BASE = 6'd15;     // fiq r8-r14
    localparam logic [MEM_AW-1:0] SPLR_BASE = 6'd22;    // irq, svc, abt, und sp/lr pairs
    localparam logic [MEM_AW-1:0] SCRATCH_BASE = 6'd30; // r8-r14 while in an unknown mode
    localparam logic [MEM_AW-1:0] SAVED_BASE = 6'd37;   // saved status words fiq..und

    localparam logic [4:0] MODE_USER = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SUPV = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    localparam logic [DATA_W-1:0] STATUS_RESET = 32'h0000_00D3;
    localparam logic [DATA_W-1:0] WMASK_USER = 32'hF80F_0200;
    localparam logic [DATA_W-1:0] WMASK_PRIV = 32'hF90F_03FF;
    localparam logic [DATA_W-1:0] KEEP_CTRL = 32'hFFFF_FF00;
    localparam logic [DATA_W-1:0] KEEP_EXT = 32'hFFFF_00FF;
    localparam logic [DATA_W-1:0] KEEP_STAT = 32'hFF00_FFFF;
    localparam logic [DATA_W-1:0] KEEP_FLAGS = 32'h00FF_FFFF;

    localparam logic [3:0] REG_PC = 4'd15;

    typedef enum logic [2:0] {
        CMD_READ    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_MRS     = 3'd2,
        CMD_MSR     = 3'd3,
        CMD_RESTORE = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_USR = 3'd0,
        KIND_FIQ = 3'd1,
        KIND_IRQ = 3'd2,
        KIND_SVC = 3'd3,
        KIND_ABT = 3'd4,
        KIND_UND = 3'd5,
        KIND_UNK = 3'd6
    } mode_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_COPY
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [MEM_AW-1:0] rd_addr;
        logic              wr_en;
        logic [MEM_AW-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

    function automatic mode_kind_t mode_kind(input logic [4:0] mode);
        mode_kind_t k;
        case (mode)
            MODE_USER, MODE_SYS: k = KIND_USR;
            MODE_FIQ:            k = KIND_FIQ;
            MODE_IRQ:            k = KIND_IRQ;
            MODE_SUPV:           k = KIND_SVC;
            MODE_ABT:            k = KIND_ABT;
            MODE_UND:            k = KIND_UND;
            default:             k = KIND_UNK;
        endcase
        return k;
    endfunction

    function automatic logic has_saved(input mode_kind_t kind);
        return (kind == KIND_FIQ) || (kind == KIND_IRQ) || (kind == KIND_SVC)
            || (kind == KIND_ABT) || (kind == KIND_UND);
    endfunction

    // memory address of a logical register r0-r14 as seen from a mode kind
    function automatic logic [MEM_AW-1:0] reg_addr(input logic [3:0] idx,
                                                   input mode_kind_t kind);
        logic [MEM_AW-1:0] off;
        logic [2:0]        pair;
        logic [MEM_AW-1:0] a;
        off  = {3'b000, idx[2:0]};
        pair = 3'(kind) - 3'(KIND_IRQ);
        if (!idx[3]) begin
            a = {2'b00, idx};
        end else begin
            case (kind)
                KIND_USR: a = USR_BASE + off;
                KIND_FIQ: a = FIQ_BASE + off;
                KIND_UNK: a = SCRATCH_BASE + off;
                default: begin
                    // r8-r12 shared with user, r13/r14 from the mode's own pair
                    if (idx < 4'd13) a = USR_BASE + off;
                    else a = SPLR_BASE + {2'b00, pair, idx[1]};
                end
            endcase
        end
        return a;
    endfunction

    function automatic logic [MEM_AW-1:0] saved_addr(input mode_kind_t kind);
        logic [2:0] n;
        n = 3'(kind) - 3'(KIND_FIQ);
        if (has_saved(kind)) return SAVED_BASE + {3'b000, n};
        return SAVED_BASE;
    endfunction

endpackage

// File: rtl/banked_register_psr_unit.sv
// banked_register_psr_unit: top level of the status word and banked register unit
// depends on bpsr_pkg, bpsr_ctrl and bpsr_regmem
//
//  channel | dir | transaction contents
//  s_      | in  | one command: command, reg_index, value, rotate, use_saved, field_mask
//  m_      | out | one result per command: read_data, status_out
//
// a command is accepted in ST_IDLE, which issues the single memory read; ST_EXEC then
// uses the registered read data and writes back. msr or restore that enters an unknown
// mode then goes through ST_COPY to copy r8-r14 into the scratch bank through the memory ports.
// reset sets the status word to 0xd3 and clears the per-entry valid bits at once, so the
// memory reads as zero without a clearing pass.
// a stalled result holds the execute cycle; a held result does not block the next accept.
module banked_register_psr_unit
    import bpsr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command[2:0], reg_index[6:3], value[38:7], rotate[42:39], use_saved[43],
    // field_mask[47:44]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // read_data[31:0], status_out[63:32]
    output logic [M_TDATA_W-1:0] m_tdata
);

    mem_req_t          mem_req;
    logic [DATA_W-1:0] mem_rdata;

    bpsr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    bpsr_regmem u_regmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (mem_rdata)
    );

endmodule

// File: rtl/bpsr_regmem.sv
// bpsr_regmem: register file memory holding r0-r14, all banks and the saved status words
// depends on bpsr_pkg; one write port, one registered read port, per-entry valid bits
module bpsr_regmem
    import bpsr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  mem_req_t          req,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0]    mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]    rdata_reg;
    logic                 rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rvalid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

// File: rtl/bpsr_ctrl.sv
// bpsr_ctrl: command sequencer, current status register, msr datapath and bank copy
// depends on bpsr_pkg; drives the request port of bpsr_regmem
module bpsr_ctrl
    import bpsr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output mem_req_t             mem_req,
    input  logic [DATA_W-1:0]    mem_rdata
);

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] status_reg;
    cmd_t              cmd_reg;
    logic [3:0]        idx_reg;
    logic [DATA_W-1:0] value_reg;
    logic [3:0]        rotate_reg;
    logic              use_saved_reg;
    logic [3:0]        fmask_reg;
    logic              m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic [2:0]        copy_cnt_reg;
    mode_kind_t        copy_kind_reg;

    cmd_t              in_cmd;
    logic [3:0]        in_idx;
    logic              accept;
    logic              out_free;
    logic              exec_go;

    mode_kind_t        cur_kind;
    mode_kind_t        new_kind;
    logic              cur_saved;
    logic [2*DATA_W-1:0] rot_dbl;
    logic [DATA_W-1:0] wmask;
    logic [DATA_W-1:0] msr_val;
    logic [DATA_W-1:0] rd_val;
    logic [DATA_W-1:0] status_next;
    logic              status_load;
    logic              ex_wr_en;
    logic [MEM_AW-1:0] ex_wr_addr;
    logic [DATA_W-1:0] ex_wr_data;
    logic              copy_start;
    logic [2:0]        copy_prev;

    assign in_cmd   = cmd_t'(s_tdata[2:0]);
    assign in_idx   = s_tdata[6:3];
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign exec_go  = (state_reg == ST_EXEC) && out_free;
    assign cur_kind = mode_kind(status_reg[4:0]);
    assign cur_saved = has_saved(cur_kind);
    assign copy_prev = copy_cnt_reg - 3'd1;

    // msr / mrs / restore datapath, uses the memory word read at accept
    always_comb begin
        rot_dbl = {value_reg, value_reg} >> {rotate_reg, 1'b0};
        wmask   = (status_reg[4:0] == MODE_USER) ? WMASK_USER : WMASK_PRIV;
        if (!fmask_reg[0]) wmask = wmask & KEEP_CTRL;
        if (!fmask_reg[1]) wmask = wmask & KEEP_EXT;
        if (!fmask_reg[2]) wmask = wmask & KEEP_STAT;
        if (!fmask_reg[3]) wmask = wmask & KEEP_FLAGS;
        msr_val = rot_dbl[DATA_W-1:0] & wmask;

        rd_val      = '0;
        status_next = status_reg;
        status_load = 1'b0;
        ex_wr_en    = 1'b0;
        ex_wr_addr  = reg_addr(idx_reg, cur_kind);
        ex_wr_data  = value_reg;
        case (cmd_reg)
            CMD_READ: begin
                if (idx_reg != REG_PC) rd_val = mem_rdata;
            end
            CMD_WRITE: begin
                ex_wr_en = (idx_reg != REG_PC);
            end
            CMD_MRS: begin
                if (!use_saved_reg) rd_val = status_reg;
                else if (cur_saved) rd_val = mem_rdata;
                ex_wr_en   = (idx_reg != REG_PC);
                ex_wr_data = rd_val;
            end
            CMD_MSR: begin
                if (use_saved_reg) begin
                    ex_wr_en   = cur_saved;
                    ex_wr_addr = saved_addr(cur_kind);
                    ex_wr_data = (mem_rdata & ~wmask) | msr_val;
                end else begin
                    status_next = msr_val | (status_reg & ~wmask);
                    status_load = 1'b1;
                end
            end
            CMD_RESTORE: begin
                if (cur_saved) begin
                    status_next = mem_rdata;
                    status_load = 1'b1;
                end
            end
            default: begin
            end
        endcase
        new_kind = mode_kind(status_next[4:0]);
        // entering an unknown mode keeps the old r8-r14 as a private copy
        copy_start = status_load && (status_next[4:0] != status_reg[4:0])
                     && (new_kind == KIND_UNK) && (cur_kind != KIND_UNK);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_EXEC;
            ST_EXEC: if (exec_go) state_next = copy_start ? ST_COPY : ST_IDLE;
            ST_COPY: if (copy_cnt_reg == 3'd7) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        mem_req         = '0;
        mem_req.wr_addr = ex_wr_addr;
        mem_req.wr_data = ex_wr_data;
        case (state_reg)
            ST_IDLE: begin
                s_tready        = 1'b1;
                mem_req.rd_en   = s_tvalid;
                mem_req.rd_addr = (in_cmd == CMD_READ) ? reg_addr(in_idx, cur_kind)
                                                       : saved_addr(cur_kind);
            end
            ST_EXEC: begin
                mem_req.wr_en = exec_go && ex_wr_en;
            end
            ST_COPY: begin
                // read source entry n while writing entry n-1 into the scratch bank
                mem_req.rd_en   = (copy_cnt_reg != 3'd7);
                mem_req.rd_addr = reg_addr({1'b1, copy_cnt_reg}, copy_kind_reg);
                mem_req.wr_en   = (copy_cnt_reg != 3'd0);
                mem_req.wr_addr = reg_addr({1'b1, copy_prev}, KIND_UNK);
                mem_req.wr_data = mem_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            status_reg   <= STATUS_RESET;
            m_valid_reg  <= 1'b0;
            copy_cnt_reg <= 3'd0;
        end else begin
            state_reg <= state_next;
            if (exec_go) begin
                status_reg   <= status_next;
                m_valid_reg  <= 1'b1;
                copy_cnt_reg <= 3'd0;
            end else begin
                if (m_tready) m_valid_reg <= 1'b0;
                if (state_reg == ST_COPY) copy_cnt_reg <= copy_cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg       <= in_cmd;
            idx_reg       <= in_idx;
            value_reg     <= s_tdata[38:7];
            rotate_reg    <= s_tdata[42:39];
            use_saved_reg <= s_tdata[43];
            fmask_reg     <= s_tdata[47:44];
        end
        if (exec_go) begin
            m_data_reg    <= {status_next, rd_val};
            copy_kind_reg <= cur_kind;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: rtl/bpsr_checker.sv
// bpsr_checker: port-level assertions for banked_register_psr_unit, bound to the top level
// depends on bpsr_pkg for the port widths
module bpsr_checker
    import bpsr_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && s_tready)
        else $error("unit not idle after reset");

    // every command needs an execute cycle before the next one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while one is executing");

    // a new result only appears after an execute cycle
    a_result_after_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result produced without an execute cycle");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind banked_register_psr_unit bpsr_checker u_bpsr_checker (.*);
